// ===== rtl/mms_pkg.sv =====
// Package with the shared types and constants of the min/max stack.
`timescale 1ns / 1ps
`default_nettype none

package mms_pkg;

  // Capacity of the stack and the widths that follow from it.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_PEEK  = 2'd3
  } op_code_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_PEEK = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_FETCH = 2'd2
  } state_t;

  // One input item.
  typedef struct packed {
    op_code_t                  op;
    logic signed [DATA_W-1:0]  argument;
  } stack_in_t;

  // One result item.
  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  peek_value;
    logic signed [DATA_W-1:0]  top_value;
    logic [CNT_W-1:0]          entry_count;
    logic signed [DATA_W-1:0]  largest;
    logic signed [DATA_W-1:0]  smallest;
    logic                      is_empty;
  } stack_out_t;

  // One stack level: the value and the running extremes of it and all levels below.
  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  run_max;
    logic signed [DATA_W-1:0]  run_min;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch;
    logic finish;
  } mms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
  } mms_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mms_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mms_ctrl.sv =====
// Controller state machine that sequences one item at a time.
`timescale 1ns / 1ps
`default_nettype none

module mms_ctrl
  import mms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire mms_stat_t stat,
  output logic           busy,
  output mms_cmd_t       cmd,
  output logic           out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = stat.need_read ? S_FETCH : S_IDLE;
      S_FETCH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands and status outputs.
  always_comb begin
    cmd           = '0;
    busy          = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        cmd.finish = !stat.need_read;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    out_valid_nxt = cmd.finish;
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted item makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  // Result strobes are never back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in consecutive cycles");

  // A memory fetch always ends in a result.
  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> out_valid)
    else $error("fetch cycle did not produce a result");

endmodule

`default_nettype wire

// ===== rtl/mms_datapath.sv =====
// Datapath: fill level, cached top entry, level memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module mms_datapath
  import mms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire stack_in_t in_data,
  input  wire mms_cmd_t  cmd,
  output mms_stat_t      stat,
  output stack_out_t     out_data
);

  stack_in_t   item_r;
  logic [LVL_W-1:0] fill_r, fill_nxt;
  entry_t      top_r, top_nxt;
  stack_out_t  res_r, res_nxt;

  entry_t      push_entry;
  entry_t      rd_data;
  status_t     status;
  logic        full;
  logic        peek_ok;
  logic        need_read;
  logic        wr_en;
  logic        rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // Level memory holding value, running max and running min per level.
  mms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_level_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(fill_r)),
    .wr_data (push_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // New level for a push, extremes taken from the cached top level.
  always_comb begin
    push_entry.value   = item_r.argument;
    push_entry.run_max = item_r.argument;
    push_entry.run_min = item_r.argument;
    if (fill_r != '0) begin
      if ($signed(top_r.run_max) > $signed(item_r.argument)) begin
        push_entry.run_max = top_r.run_max;
      end
      if ($signed(top_r.run_min) < $signed(item_r.argument)) begin
        push_entry.run_min = top_r.run_min;
      end
    end
  end

  assign full    = (fill_r == LVL_W'(DEPTH));
  // A negative depth is a huge unsigned value and fails this test.
  assign peek_ok = (item_r.argument < DATA_W'(fill_r));

  // Operation decode in the execute cycle.
  always_comb begin
    fill_nxt  = fill_r;
    top_nxt   = top_r;
    status    = ST_OK;
    need_read = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    case (item_r.op)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          wr_en    = cmd.exec;
          fill_nxt = fill_r + LVL_W'(1);
          top_nxt  = push_entry;
        end
      end
      OP_POP: begin
        if (fill_r == '0) begin
          status = ST_EMPTY;
        end else begin
          fill_nxt = fill_r - LVL_W'(1);
          if (fill_r > LVL_W'(1)) begin
            need_read = 1'b1;
            rd_addr   = ADDR_W'(fill_r - LVL_W'(2));
          end
        end
      end
      OP_CLEAR: begin
        fill_nxt = '0;
      end
      OP_PEEK: begin
        if (peek_ok) begin
          need_read = 1'b1;
          rd_addr   = ADDR_W'(fill_r) - ADDR_W'(1) - item_r.argument[ADDR_W-1:0];
        end else begin
          status = ST_BAD_PEEK;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign rd_en          = cmd.exec && need_read;
  assign stat.need_read = need_read;

  // Result assembly from the state after the operation.
  always_comb begin
    logic [LVL_W-1:0] fill_after;
    entry_t           top_after;
    res_nxt.peek_value = '0;
    if (cmd.fetch) begin
      fill_after     = fill_r;
      top_after      = (item_r.op == OP_POP) ? rd_data : top_r;
      res_nxt.status = ST_OK;
      if (item_r.op == OP_PEEK) begin
        res_nxt.peek_value = rd_data.value;
      end
    end else begin
      fill_after     = fill_nxt;
      top_after      = top_nxt;
      res_nxt.status = status;
    end
    res_nxt.entry_count = CNT_W'(fill_after);
    if (fill_after == '0) begin
      res_nxt.top_value = '0;
      res_nxt.largest   = '0;
      res_nxt.smallest  = '0;
      res_nxt.is_empty  = 1'b1;
    end else begin
      res_nxt.top_value = top_after.value;
      res_nxt.largest   = top_after.run_max;
      res_nxt.smallest  = top_after.run_min;
      res_nxt.is_empty  = 1'b0;
    end
  end

  // Fill level is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

  // Item, cached top level and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      top_r <= top_nxt;
    end else if (cmd.fetch && item_r.op == OP_POP) begin
      top_r <= rd_data;
    end
    if (cmd.finish) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

  // The fill level never passes the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LVL_W'(DEPTH))
    else $error("fill level above capacity");

  // A successful push raises the fill level by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && item_r.op == OP_PUSH && !full)
      |=> (fill_r == LVL_W'($past(fill_r) + LVL_W'(1))))
    else $error("push did not advance the fill level");

endmodule

`default_nettype wire

// ===== rtl/min_max_stack_core.sv =====
// Top level of the bounded stack with running maximum, minimum and peek.
//
// Usage: drive an item on in_data (op and argument) and raise start. The item
// is taken at a rising edge where start is high and busy is low; busy then
// stays high until the block can take the next item. Each item produces one
// result on out_data, marked by a one-cycle out_valid strobe; the receiver
// must take it in that cycle, there is no way to hold it off.
// Push, clear, a pop that leaves the stack empty and every failed operation
// pass through the execute state only; a pop that leaves entries and a valid
// peek read the level memory, whose registered read port adds a fetch state
// after the execute state. A new item is taken only once the block is through
// with the last one, so items never overlap.
// Running maximum and minimum are stored per level, so largest and smallest
// come from the top level without a scan.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; the memory contents are left as they are and are only read below
// the fill level.
`timescale 1ns / 1ps
`default_nettype none

module min_max_stack_core
  import mms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire stack_in_t  in_data,
  output logic            out_valid,
  output stack_out_t      out_data
);

  mms_cmd_t  cmd;
  mms_stat_t stat;

  // Sequencing of one item.
  mms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // Stack storage and result computation.
  mms_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/tb_min_max_stack_core.sv =====
// Self-checking testbench for the min/max stack with peek: directed table, then random bursts.
`timescale 1ns / 1ps

module tb_min_max_stack_core;
  import mms_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYC  = 8;
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

  // One row of the directed table: the item and, where it is obvious, the result.
  typedef struct {
    stack_in_t  item;
    bit         typed;
    stack_out_t result;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  stack_in_t  in_data;
  logic       out_valid;
  stack_out_t out_data;

  // Shadow copy of the stack, updated as each item is accepted.
  logic signed [DATA_W-1:0] shadow_value [DEPTH];
  logic signed [DATA_W-1:0] shadow_max   [DEPTH];
  logic signed [DATA_W-1:0] shadow_min   [DEPTH];
  int                       shadow_fill;

  stack_out_t pending_results[$];
  dir_row_t   dir_rows[$];

  int sender_idle_pct;
  int items_sent;
  int results_checked;
  int mismatch_count;
  int cycle_count;
  int op_seen[4];
  int status_seen[4];

  min_max_stack_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one operation to the shadow stack and returns the snapshot it yields.
  function automatic stack_out_t apply_stack_op(input stack_in_t item);
    stack_out_t       res;
    logic [DATA_W-1:0] depth;
    res        = '0;
    res.status = ST_OK;
    depth      = item.argument;
    case (item.op)
      OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_value[shadow_fill] = item.argument;
          shadow_max[shadow_fill]   = item.argument;
          shadow_min[shadow_fill]   = item.argument;
          if (shadow_fill > 0) begin
            if (shadow_max[shadow_fill-1] > $signed(item.argument))
              shadow_max[shadow_fill] = shadow_max[shadow_fill-1];
            if (shadow_min[shadow_fill-1] < $signed(item.argument))
              shadow_min[shadow_fill] = shadow_min[shadow_fill-1];
          end
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) res.status = ST_EMPTY;
        else shadow_fill--;
      end
      OP_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
        // A negative depth is a huge unsigned one and always fails.
        if (depth < shadow_fill) res.peek_value = shadow_value[shadow_fill - 1 - int'(depth)];
        else res.status = ST_BAD_PEEK;
      end
    endcase
    res.entry_count = CNT_W'(shadow_fill);
    if (shadow_fill > 0) begin
      res.top_value = shadow_value[shadow_fill-1];
      res.largest   = shadow_max[shadow_fill-1];
      res.smallest  = shadow_min[shadow_fill-1];
      res.is_empty  = 1'b0;
    end else begin
      res.is_empty = 1'b1;
    end
    return res;
  endfunction

  function automatic dir_row_t checked_row(input op_code_t op, input logic [DATA_W-1:0] arg);
    dir_row_t row;
    row.item.op       = op;
    row.item.argument = arg;
    row.typed         = 1'b0;
    row.result        = '0;
    return row;
  endfunction

  // The empty flag follows from the count, so it is not typed separately.
  function automatic dir_row_t typed_row(input op_code_t op, input logic [DATA_W-1:0] arg,
                                         input status_t st, input logic [DATA_W-1:0] pk,
                                         input logic [DATA_W-1:0] top, input int cnt,
                                         input logic [DATA_W-1:0] hi,
                                         input logic [DATA_W-1:0] lo);
    dir_row_t row;
    row                    = checked_row(op, arg);
    row.typed              = 1'b1;
    row.result.status      = st;
    row.result.peek_value  = pk;
    row.result.top_value   = top;
    row.result.entry_count = CNT_W'(cnt);
    row.result.largest     = hi;
    row.result.smallest    = lo;
    row.result.is_empty    = (cnt == 0);
    return row;
  endfunction

  // Values skewed toward the extremes and small numbers, so ties are common.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return INT_MAX;
      1:       return INT_MIN;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Peek depths: mostly in range, with the boundary and negative depths mixed in.
  function automatic logic [DATA_W-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && shadow_fill > 0) return $urandom_range(0, shadow_fill - 1);
    case (r)
      6:       return shadow_fill;
      7:       return '1;
      8:       return $urandom();
      default: return '0;
    endcase
  endfunction

  // Presents one item after a random gap and records its expected result on acceptance.
  task automatic issue(input stack_in_t item, input bit typed, input stack_out_t typed_res);
    stack_out_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start   <= 1'b0;
      in_data <= {2'($urandom()), $urandom()};
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_stack_op(item);
    pending_results.push_back(typed ? typed_res : predicted);
    op_seen[int'(item.op)]++;
    status_seen[int'(predicted.status)]++;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send(input op_code_t op, input logic [DATA_W-1:0] arg);
    stack_in_t item;
    item.op       = op;
    item.argument = arg;
    issue(item, 1'b0, '0);
  endtask

  // Pushes until the stack is full, then a few more that must be refused.
  task automatic fill_and_overflow();
    while (shadow_fill < DEPTH) send(OP_PUSH, pick_value());
    repeat ($urandom_range(1, 3)) send(OP_PUSH, pick_value());
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random bursts of well-formed activity, with some noise, up to a total item count.
  task automatic random_phase(input int target, input int idle_pct);
    int kind;
    sender_idle_pct = idle_pct;
    fill_and_overflow();
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 32) begin
        repeat ($urandom_range(1, 24)) send(OP_PUSH, pick_value());
      end else if (kind < 57) begin
        repeat ($urandom_range(1, 24)) send(OP_POP, $urandom());
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 8)) send(OP_PEEK, pick_depth());
      end else if (kind < 81) begin
        fill_and_overflow();
      end else if (kind < 86) begin
        send(OP_CLEAR, $urandom());
      end else begin
        repeat ($urandom_range(1, 8)) send(op_code_t'($urandom_range(0, 3)), $urandom());
      end
    end
    drain();
  endtask

  task automatic compare_result(input stack_out_t want, input stack_out_t got);
    bit bad;
    bad = 1'b0;
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      bad = 1'b1;
    end
    if (got.peek_value !== want.peek_value) begin
      $error("peek_value: expected %0d, got %0d", want.peek_value, got.peek_value);
      bad = 1'b1;
    end
    if (got.top_value !== want.top_value) begin
      $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
      bad = 1'b1;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      bad = 1'b1;
    end
    if (got.largest !== want.largest) begin
      $error("largest: expected %0d, got %0d", want.largest, got.largest);
      bad = 1'b1;
    end
    if (got.smallest !== want.smallest) begin
      $error("smallest: expected %0d, got %0d", want.smallest, got.smallest);
      bad = 1'b1;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
      bad = 1'b1;
    end
    if (bad) mismatch_count++;
  endtask

  // Every strobed result is matched against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result strobed with no item outstanding");
        mismatch_count++;
      end else begin
        compare_result(pending_results.pop_front(), out_data);
        results_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    shadow_fill = 0;

    // Directed table: empty-stack corner cases, the extremes of the value range,
    // peek depths at and beyond the boundaries, and emptying by pop and by clear.
    dir_rows.push_back(typed_row(OP_POP,   '0,      ST_EMPTY,    '0, '0, 0, '0, '0));
    dir_rows.push_back(typed_row(OP_PEEK,  '0,      ST_BAD_PEEK, '0, '0, 0, '0, '0));
    dir_rows.push_back(typed_row(OP_CLEAR, '1,      ST_OK,       '0, '0, 0, '0, '0));
    dir_rows.push_back(typed_row(OP_PUSH,  INT_MAX, ST_OK, '0, INT_MAX, 1, INT_MAX, INT_MAX));
    dir_rows.push_back(typed_row(OP_PUSH,  INT_MIN, ST_OK, '0, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(typed_row(OP_PEEK,  32'd1, ST_OK, INT_MAX, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(typed_row(OP_PEEK,  32'd0, ST_OK, INT_MIN, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(typed_row(OP_PEEK,  32'd2, ST_BAD_PEEK, '0, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(typed_row(OP_PEEK,  '1,    ST_BAD_PEEK, '0, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(typed_row(OP_PEEK,  INT_MAX, ST_BAD_PEEK, '0, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(typed_row(OP_PEEK,  INT_MIN, ST_BAD_PEEK, '0, INT_MIN, 2, INT_MAX, INT_MIN));
    dir_rows.push_back(checked_row(OP_PUSH, '0));
    dir_rows.push_back(checked_row(OP_PUSH, '1));
    dir_rows.push_back(checked_row(OP_PUSH, 32'd1));
    dir_rows.push_back(checked_row(OP_POP,  32'hFFFF_0000));
    dir_rows.push_back(checked_row(OP_PEEK, 32'd2));
    dir_rows.push_back(checked_row(OP_POP,  '0));
    dir_rows.push_back(checked_row(OP_POP,  '1));
    dir_rows.push_back(checked_row(OP_POP,  32'h0000_FFFF));
    dir_rows.push_back(typed_row(OP_POP,   '0, ST_OK,    '0, '0, 0, '0, '0));
    dir_rows.push_back(typed_row(OP_POP,   '0, ST_EMPTY, '0, '0, 0, '0, '0));
    dir_rows.push_back(checked_row(OP_PUSH, 32'h5555_5555));
    dir_rows.push_back(checked_row(OP_PUSH, 32'hAAAA_AAAA));
    dir_rows.push_back(typed_row(OP_CLEAR, 32'h1234_5678, ST_OK, '0, '0, 0, '0, '0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 16;
    foreach (dir_rows[i]) issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    drain();

    // Sender gaps light, then heavy, then none at all.
    random_phase(640, 16);
    random_phase(1250, 78);
    random_phase(1850, 0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Summary: %0d items (%0d push, %0d pop, %0d clear, %0d peek), %0d results checked.",
             items_sent, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_CLEAR],
             op_seen[OP_PEEK], results_checked);
    $display("Summary: %0d pushes refused when full, %0d pops on empty, %0d out-of-range peeks.",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_BAD_PEEK]);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
